@@ sv/dense_dijkstra_shortest_path_top_defines.svh @@
// Assertion macros shared by the shortest-path block.
`ifndef DENSE_DIJKSTRA_SHORTEST_PATH_TOP_DEFINES_SVH
`define DENSE_DIJKSTRA_SHORTEST_PATH_TOP_DEFINES_SVH
// Implication checked on every edge outside reset.
`define DD_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Implication checked in the cycle after the antecedent.
`define DD_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ sv/ddsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ddsp_pkg
// Types and constants shared by the shortest-path controller and datapath.
// ----------------------------------------------------------------------------
package ddsp_pkg;
  localparam int MAX_NODES  = 64;
  localparam int COST_WIDTH = 16;
  localparam int DIST_W = 22;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;
  localparam logic [0:0] REG_NODE_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_INIT, ST_SCAN, ST_PICK, ST_RELAX, ST_RWAIT, ST_EMIT, ST_EWAIT
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic clear;      // clear one arc present bit of the clearing pass
    logic init;       // clear one node of the per-run arrays
    logic set_src;    // mark the source reachable
    logic scan;       // test node at index for minimum
    logic scan_start; // clear the running minimum
    logic settle;     // settle the chosen node
    logic rd;         // issue memory reads at index
    logic relax;      // relax the arc read in the previous cycle
    logic emit_rd;    // read result fields at index
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic found;
    logic clear_done;
  } status_t;
endpackage

@@ sv/ddsp_datapath.sv @@
// ----------------------------------------------------------------------------
// ddsp_datapath
// Arc memories, per-node distance state, minimum search and relaxation.
// ----------------------------------------------------------------------------
module ddsp_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ddsp_pkg::cmd_t        cmd,
  output ddsp_pkg::status_t     status,
  input  logic [5:0]            idx,
  input  logic [5:0]            src,
  input  logic                  load_we,
  input  logic [5:0]            from_node,
  input  logic [5:0]            to_node,
  input  logic [15:0]           arc_cost,
  input  logic                  arc_present,
  output logic [ddsp_pkg::DIST_W-1:0] r_dist,
  output logic [5:0]            r_pred,
  output logic                  r_reach
);
  import ddsp_pkg::*;
  localparam int IW = $clog2(MAX_NODES);
  localparam int AW = 2 * IW;

  logic [COST_WIDTH-1:0] cost_mem [0:MAX_NODES*MAX_NODES-1];
  logic exists_mem [0:MAX_NODES*MAX_NODES-1];
  logic [DIST_W-1:0] node_dist [0:MAX_NODES-1];
  logic [5:0] pred [0:MAX_NODES-1];
  logic [MAX_NODES-1:0] reach, setl;
  logic [DIST_W-1:0] best, sd, rd_dist;
  logic [IW-1:0] h, j_q, sidx;
  logic found, rd_ex, scan_v;
  logic [COST_WIDTH-1:0] rd_cost;
  logic [DIST_W-1:0] hdist;
  logic [IW-1:0] ii;
  logic [AW-1:0] waddr, raddr, clr_addr;
  logic [DIST_W:0] sum;
  logic [DIST_W-1:0] d;
  logic [15:0] cost_in;

  assign ii = idx[IW-1:0];
  assign waddr = {from_node[IW-1:0], to_node[IW-1:0]};
  assign raddr = {h, ii};
  assign cost_in = arc_cost;
  assign status.found = found;
  assign status.clear_done = (clr_addr == {AW{1'b1}});

  // Arc storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (load_we) cost_mem[waddr] <= cost_in[COST_WIDTH-1:0];
    if (cmd.rd) begin
      rd_cost <= cost_mem[raddr];
      j_q <= ii;
    end
  end

  // Clearing pass address, stepped once per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Arc present bits: cleared one entry per cycle after reset, then written by loads.
  always_ff @(posedge clk) begin
    if (cmd.clear) exists_mem[clr_addr] <= 1'b0;
    else if (load_we) exists_mem[waddr] <= arc_present;
    if (cmd.rd) rd_ex <= exists_mem[raddr];
  end

  // Registered reads of the distance store for the search and the relaxation.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      sd <= node_dist[ii];
      sidx <= ii;
    end
    if (cmd.rd) rd_dist <= node_dist[ii];
  end

  // Relaxation sum with saturation.
  assign sum = {1'b0, hdist} + (DIST_W+1)'(rd_cost);
  assign d = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  // Per-node state, minimum search and relaxation.
  always_ff @(posedge clk) begin
    if (rst) begin
      reach <= '0;
      setl <= '0;
      found <= 1'b0;
      scan_v <= 1'b0;
    end else begin
      scan_v <= cmd.scan;
      if (cmd.init) begin
        reach[ii] <= 1'b0;
        setl[ii] <= 1'b0;
        node_dist[ii] <= '0;
        pred[ii] <= src;
      end
      if (cmd.set_src) reach[src[IW-1:0]] <= 1'b1;
      if (cmd.scan_start) found <= 1'b0;
      if (scan_v && !setl[sidx] && reach[sidx] && (!found || sd < best)) begin
        found <= 1'b1;
        best <= sd;
        h <= sidx;
      end
      if (cmd.settle) begin
        setl[h] <= 1'b1;
        hdist <= node_dist[h];
      end
      if (cmd.relax && rd_ex && !setl[j_q] && (!reach[j_q] || d < rd_dist)) begin
        reach[j_q] <= 1'b1;
        node_dist[j_q] <= d;
        pred[j_q] <= 6'(h);
      end
    end
  end

  // Result read.
  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      r_reach <= reach[ii];
      r_dist <= reach[ii] ? node_dist[ii] : '0;
      r_pred <= reach[ii] ? pred[ii] : src;
    end
  end
endmodule

@@ sv/ddsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ddsp_ctrl
// Sequencer for the clearing pass, initialisation, selection, relaxation and result transfer.
// ----------------------------------------------------------------------------
`include "dense_dijkstra_shortest_path_top_defines.svh"
module ddsp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [5:0]        source_node,
  input  logic [6:0]        n_use,
  output ddsp_pkg::cmd_t    cmd,
  input  ddsp_pkg::status_t status,
  output logic [5:0]        idx,
  output logic [5:0]        src,
  output logic              load_we,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        node,
  output logic              last
);
  import ddsp_pkg::*;
  state_t state, state_next;
  logic [6:0] cnt, cnt_next, n, n_next;
  logic [5:0] src_next;
  logic [6:0] rounds, rounds_next;
  logic ov_next, hold;

  assign idx = cnt[5:0];
  assign in_stall = (state != ST_IDLE);
  assign load_we = in_valid && !in_stall && op == OP_LOAD;
  assign hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= ov_next;
    end
    cnt <= cnt_next;
    n <= n_next;
    src <= src_next;
    rounds <= rounds_next;
    if (cmd.emit_rd) begin
      node <= cnt[5:0];
      last <= (cnt + 7'd1 == n);
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    n_next = n;
    src_next = src;
    rounds_next = rounds;
    ov_next = out_valid && out_stall;
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && op == OP_RUN) begin
          n_next = n_use;
          src_next = source_node;
          cnt_next = '0;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init = 1'b1;
        cnt_next = cnt + 7'd1;
        if (cnt + 7'd1 == n) begin
          cnt_next = '0;
          rounds_next = '0;
          cmd.scan_start = 1'b1;
          if ({1'b0, src} < n) begin
            cmd.set_src = 1'b1;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      // Reads are issued for n nodes; the final step at cnt == n issues none and lets the last compare land.
      ST_SCAN: begin
        cmd.scan = (cnt != n);
        cnt_next = cnt + 7'd1;
        if (cnt == n) state_next = ST_PICK;
      end
      ST_PICK: begin
        cnt_next = '0;
        if (status.found) begin
          cmd.settle = 1'b1;
          state_next = ST_RELAX;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_RELAX: begin
        cmd.rd = 1'b1;
        cmd.relax = (cnt != 7'd0);
        cnt_next = cnt + 7'd1;
        if (cnt + 7'd1 == n) state_next = ST_RWAIT;
      end
      ST_RWAIT: begin
        cmd.relax = 1'b1;
        cnt_next = '0;
        cmd.scan_start = 1'b1;
        rounds_next = rounds + 7'd1;
        state_next = (rounds + 7'd1 == n) ? ST_EMIT : ST_SCAN;
      end
      ST_EMIT: begin
        if (!hold) begin
          cmd.emit_rd = 1'b1;
          ov_next = 1'b1;
          cnt_next = cnt + 7'd1;
          state_next = (cnt + 7'd1 == n) ? ST_EWAIT : ST_EMIT;
        end
      end
      ST_EWAIT: begin
        if (!hold) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `DD_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, in_stall, "accepted while busy")
  `DD_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid && $stable(node), "result dropped")
  `DD_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit_rd, !(out_valid && out_stall), "result overwritten")
endmodule

@@ sv/dense_dijkstra_shortest_path_top.sv @@
// ----------------------------------------------------------------------------
// dense_dijkstra_shortest_path_top
// Dijkstra shortest paths over a dense arc matrix held in on-chip memory.
// ----------------------------------------------------------------------------
// Load items are accepted back to back while the block is idle. A run is
// accepted, initialises its n nodes, then for at most n rounds scans the nodes,
// picks the nearest unsettled one and relaxes its arcs, then makes n result transfers.
// Reset is synchronous: node_count returns to 64 and a clearing pass over all
// 4096 arc entries clears the arc present bits while the input is stalled.
module dense_dijkstra_shortest_path_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [5:0]  from_node,
  input  logic [5:0]  to_node,
  input  logic [15:0] arc_cost,
  input  logic        arc_present,
  input  logic [5:0]  source_node,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  node,
  output logic [21:0] distance,
  output logic [5:0]  predecessor,
  output logic        reachable,
  output logic        last
);
  import ddsp_pkg::*;
  logic [6:0] node_count, n_use;
  cmd_t cmd;
  status_t status;
  logic [5:0] idx, src;
  logic load_we;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) node_count <= 7'd64;
    else if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT)
      node_count <= pwdata[6:0];
  end
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {25'd0, node_count} : 32'd0;

  // Node count saturated to the supported range.
  always_comb begin
    if (node_count < 7'd2) n_use = 7'd2;
    else if (node_count > 7'(MAX_NODES)) n_use = 7'(MAX_NODES);
    else n_use = node_count;
  end

  ddsp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .op, .source_node, .n_use, .cmd, .status,
    .idx, .src, .load_we, .out_valid, .out_stall, .node, .last
  );

  ddsp_datapath u_dp (
    .clk, .rst, .cmd, .status, .idx, .src, .load_we, .from_node, .to_node,
    .arc_cost, .arc_present, .r_dist(distance), .r_pred(predecessor),
    .r_reach(reachable)
  );
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest-path block testbench
// Loads arcs into the cost matrix, starts searches from chosen sources and
// checks every emitted node result against a search computed in the bench,
// under random idling on both channels, a long output hold-off and a sweep
// of node counts including the saturated extremes.
// ----------------------------------------------------------------------------
module tb;
  import ddsp_pkg::*;

  localparam int NODES      = 64;
  localparam int DMAX       = 4194303;
  localparam int WDOG_LIMIT = 100000;
  localparam int SETTLE_CYC = 40;

  typedef struct packed {
    logic [5:0]  node;
    logic [21:0] path_dist;
    logic [5:0]  pred;
    logic        reach;
    logic        last;
  } path_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_LOAD;
  logic [5:0]  from_node = '0, to_node = '0, source_node = '0;
  logic [15:0] arc_cost = '0;
  logic        arc_present = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  node, predecessor;
  logic [21:0] distance;
  logic        reachable, last;

  // Mirror of the block's graph and register.
  logic [15:0] cost_mirror [NODES*NODES];
  logic        arc_mirror  [NODES*NODES];
  logic [6:0]  node_count_mirror;

  path_res_t   path_q [$];
  int          mismatches = 0;
  int          send_pct = 0, recv_pct = 0;
  int          hold_len = 0, hold_gen = 0;
  int          hold_seen = 0, hold_left = 0;
  int          quiet_cycles = 0;

  dense_dijkstra_shortest_path_top dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .from_node(from_node), .to_node(to_node), .arc_cost(arc_cost),
    .arc_present(arc_present), .source_node(source_node),
    .out_valid(out_valid), .out_stall(out_stall),
    .node(node), .distance(distance), .predecessor(predecessor),
    .reachable(reachable), .last(last)
  );

  always #10 clk = ~clk;

  // Work out the node results of one search and queue them.
  function automatic void predict_paths(input logic [5:0] src);
    int n, h, best, sum;
    bit found;
    int  dist_a [NODES];
    int  pred [NODES];
    bit  reach [NODES];
    bit  done [NODES];
    path_res_t r;
    n = node_count_mirror < 2 ? 2 : (node_count_mirror > NODES ? NODES : node_count_mirror);
    for (int j = 0; j < n; j++) begin
      dist_a[j] = 0; pred[j] = src; reach[j] = 0; done[j] = 0;
    end
    if (src < n) begin
      reach[src] = 1;
      for (int round = 0; round < n; round++) begin
        found = 0; best = 0; h = 0;
        for (int j = 0; j < n; j++)
          if (!done[j] && reach[j] && (!found || dist_a[j] < best)) begin
            found = 1; best = dist_a[j]; h = j;
          end
        if (!found) break;
        done[h] = 1;
        for (int j = 0; j < n; j++) begin
          if (!arc_mirror[h*NODES+j] || done[j]) continue;
          sum = dist_a[h] + cost_mirror[h*NODES+j];
          if (sum > DMAX) sum = DMAX;
          if (!reach[j] || sum < dist_a[j]) begin
            reach[j] = 1; dist_a[j] = sum; pred[j] = h;
          end
        end
      end
    end
    for (int j = 0; j < n; j++) begin
      r.node      = 6'(j);
      r.path_dist = reach[j] ? 22'(dist_a[j]) : '0;
      r.pred      = reach[j] ? 6'(pred[j]) : src;
      r.reach     = reach[j];
      r.last      = (j == n - 1);
      path_q.push_back(r);
    end
  endfunction

  // Offer one item and wait for its transfer.
  task automatic send_item(input logic o, input logic [5:0] f, input logic [5:0] t,
                           input logic [15:0] c, input logic p, input logic [5:0] s);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o; from_node <= f; to_node <= t;
    arc_cost <= c; arc_present <= p; source_node <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (o == OP_LOAD) begin
      cost_mirror[f*NODES+t] = c;
      arc_mirror[f*NODES+t]  = p;
    end else begin
      predict_paths(s);
    end
  endtask

  // Stop offering and wait for every expected result, then let the block settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (path_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write the node count register; the block must be idle.
  task automatic write_node_count(input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(4 * REG_NODE_COUNT); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    node_count_mirror = val[6:0];
  endtask

  task automatic send_run(input logic [5:0] s);
    send_item(OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom), s);
  endtask

  task automatic send_arc(input int f, input int t, input int c, input bit p);
    send_item(OP_LOAD, 6'(f), 6'(t), 16'(c), p, 6'($urandom));
  endtask

  // Hand-picked graph: ties, extreme costs, removed arcs and a bad source.
  task automatic test_directed;
    write_node_count(32'd4);
    send_arc(0, 1, 5, 1);
    send_arc(0, 2, 5, 1);
    send_arc(1, 3, 65535, 1);
    send_arc(2, 3, 65535, 1);
    send_arc(3, 0, 0, 1);
    send_arc(63, 63, 65535, 1);
    send_arc(1, 2, 0, 0);
    send_run(6'd0);
    send_run(6'd3);
    send_run(6'd63);
    send_run(6'd4);
    send_arc(0, 1, 0, 0);
    send_arc(2, 1, 0, 1);
    send_run(6'd0);
    drain();
    // Counts below the range saturate to two nodes.
    write_node_count(32'd0);
    send_run(6'd0);
    send_run(6'd1);
    send_run(6'd2);
    drain();
    write_node_count(32'hFFFF_FF81);
    send_run(6'd1);
    drain();
  endtask

  // Random graphs over small node counts, a few runs per graph.
  task automatic test_random(input int s_pct, input int r_pct, input int items);
    int sent, n, k, cfg;
    send_pct = s_pct;
    recv_pct = r_pct;
    sent = 0;
    while (sent < items) begin
      drain();
      case ($urandom_range(9))
        0:       cfg = $urandom_range(1);
        1:       cfg = $urandom_range(9, 16);
        default: cfg = $urandom_range(2, 8);
      endcase
      write_node_count({25'($urandom_range(32'h1FF_FFFF)), 7'(cfg)});
      n = cfg < 2 ? 2 : cfg;
      k = $urandom_range(2 * n + 2, 1);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(9) == 0)
          send_item(OP_LOAD, 6'($urandom), 6'($urandom), 16'($urandom), 1'($urandom),
                    6'($urandom));
        else
          send_arc($urandom_range(n - 1), $urandom_range(n - 1),
                   $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(20),
                   $urandom_range(4) != 0);
      end
      sent += k;
      for (int i = $urandom_range(3, 1); i > 0; i--) begin
        send_run($urandom_range(5) == 0 ? 6'($urandom) : 6'($urandom_range(n - 1)));
        sent++;
      end
    end
    drain();
  endtask

  // The receiver holds off while loads keep coming, so the input backs up.
  task automatic test_backpressure;
    send_pct = 0;
    recv_pct = 0;
    write_node_count(32'd6);
    hold_len = 3000;
    hold_gen++;
    send_run(6'd2);
    for (int i = 0; i < 30; i++)
      send_arc($urandom_range(5), $urandom_range(5), $urandom_range(65535), 1);
    send_run(6'd0);
    drain();
  endtask

  // Full-size graphs at the largest count, reached directly and by saturation.
  task automatic test_full_size;
    send_pct = 10;
    recv_pct = 10;
    write_node_count(32'd64);
    for (int i = 0; i < 40; i++)
      send_arc($urandom_range(63), $urandom_range(63), $urandom_range(65535), 1);
    send_run(6'd63);
    drain();
    write_node_count(32'd127);
    send_run(6'($urandom));
    drain();
  endtask

  // Receiver: random stalls, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_gen) begin
      hold_seen <= hold_gen;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    path_res_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{node, distance, predecessor, reachable, last};
      if (path_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: node %0d dist %0d pred %0d reach %0b last %0b",
                   node, distance, predecessor, reachable, last);
      end else begin
        want = path_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp node %0d dist %0d pred %0d reach %0b last %0b, ",
                      "got node %0d dist %0d pred %0d reach %0b last %0b"},
                     want.node, want.path_dist, want.pred, want.reach, want.last,
                     node, distance, predecessor, reachable, last);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NODES * NODES; i++) begin
      arc_mirror[i]  = 1'b0;
      cost_mirror[i] = '0;
    end
    node_count_mirror = 7'd64;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(28, 72, 40);
    test_random(72, 28, 40);
    test_random(0, 0, 40);
    test_backpressure();
    test_full_size();
    drain();
    if (mismatches == 0 && path_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+sv
sv/ddsp_pkg.sv
sv/ddsp_datapath.sv
sv/ddsp_ctrl.sv
sv/dense_dijkstra_shortest_path_top.sv
tb/tb.sv
